>>> hdl/ufe_pkg.sv
`default_nettype none

package ufe_pkg;

    // Element count of the forest and derived widths
    localparam int NODES   = 1024;
    localparam int IDX_W   = $clog2(NODES);
    localparam int SIZE_W  = $clog2(NODES + 1);
    localparam int FIELD_W = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [FIELD_W-1:0] UNASG      = '1;
    localparam logic [FIELD_W-1:0] NODE_LIMIT = FIELD_W'(NODES);
    localparam logic [FIELD_W-1:0] CFG_RESET  = 11'd1024;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [FIELD_W-1:0] t_field;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND  = 2'd0,
        CMD_UNITE = 2'd1,
        CMD_SAME  = 2'd2,
        CMD_SIZE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNASG = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CLS_OK,
        CLS_UNASG,
        CLS_RANGE
    } t_cls;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_NEXT,
        S_SZ,
        S_USZA,
        S_USZB,
        S_RESP
    } t_state;

    // Sort a raw index into valid, unassigned or out of range
    function automatic t_cls classify(input t_field v, input t_field lim);
        t_cls c;
        if (v == UNASG) begin
            c = CLS_UNASG;
        end else if (v[FIELD_W-1]) begin
            c = CLS_RANGE;
        end else if (v >= lim) begin
            c = CLS_RANGE;
        end else begin
            c = CLS_OK;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ufe_if.sv
`default_nettype none

interface ufe_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [ufe_pkg::CMD_W-1:0]             cmd;
    logic signed [ufe_pkg::FIELD_W-1:0]    index_a;
    logic signed [ufe_pkg::FIELD_W-1:0]    index_b;

    modport source (output valid, output cmd, output index_a, output index_b, input ready);
    modport sink   (input valid, input cmd, input index_a, input index_b, output ready);
endinterface

interface ufe_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ufe_pkg::FIELD_W-1:0]    root;
    logic                                  is_same;
    logic [ufe_pkg::FIELD_W-1:0]           group_size;
    logic [ufe_pkg::STAT_W-1:0]            status;

    modport source (output valid, output root, output is_same, output group_size,
                    output status, input ready);
    modport sink   (input valid, input root, input is_same, input group_size,
                    input status, output ready);
endinterface

`default_nettype wire

>>> hdl/union_find_engine_unit.sv
// Disjoint-set engine with union by size and full path compression over 1024
// elements. One command at a time; the input is not ready while a command
// runs. Each link step is one access to the parent memory. A find walks to
// the root, rewrites each link on the way back to point at the root, then
// records the root and forms the result; size also reads the group size of
// the root. Same on two valid indices runs a find on each, and with one index
// unassigned it runs a single find; unite on two valid indices runs a find on
// each, then compares the sizes and links when the roots differ; unite with an
// unassigned b only walks a's path. Range errors and commands with nothing to
// walk go straight to forming the result. The input is ready again in the
// cycle the result appears; a result that waits on the output holds the next
// command in its last step. After reset a clearing pass over all 1024 entries
// loads the parent and size memories before the first command is taken;
// node_count writes are taken at any time.
`default_nettype none

module union_find_engine_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [ufe_pkg::FIELD_W-1:0]  i_cfg_wdata,
    ufe_in_if.sink                            i_in,
    ufe_out_if.source                         o_out
);

    // Registers
    ufe_pkg::t_state  r_state, n_state;
    ufe_pkg::t_idx    r_clr, n_clr;
    ufe_pkg::t_field  r_node_cnt;
    ufe_pkg::t_cmd    r_cmd, n_cmd;
    ufe_pkg::t_cls    r_ca, n_ca, r_cb, n_cb;
    ufe_pkg::t_idx    r_b, n_b;
    ufe_pkg::t_idx    r_cur, n_cur, r_start, n_start, r_root, n_root;
    ufe_pkg::t_idx    r_ra, n_ra, r_rb, n_rb;
    logic             r_on_b, n_on_b, r_walk_only, n_walk_only;
    ufe_pkg::t_size   r_gsz, n_gsz, r_sza, n_sza;
    logic             r_ov, n_ov;
    ufe_pkg::t_field  r_o_root, n_o_root, r_o_gsz, n_o_gsz;
    logic             r_o_same, n_o_same;
    ufe_pkg::t_status r_o_status, n_o_status;

    // Memories and their ports
    ufe_pkg::t_idx    r_par_mem [ufe_pkg::NODES];
    ufe_pkg::t_size   r_sz_mem  [ufe_pkg::NODES];
    ufe_pkg::t_idx    r_par_q;
    ufe_pkg::t_size   r_sz_q;
    logic             par_we, sz_we;
    ufe_pkg::t_idx    par_wa, par_wd, par_ra, sz_wa, sz_ra;
    ufe_pkg::t_size   sz_wd, sz_sum;

    // Decode of the incoming command
    ufe_pkg::t_field  limit, a_raw, b_raw;
    ufe_pkg::t_cmd    cmd_in;
    ufe_pkg::t_cls    ca_in, cb_in;
    logic             in_ready, accept, uses_b_in, err_in, start_a, start_b;
    logic             walk_found, comp_done, need_b, link_needed, out_free;

    // Result fields formed from the finished command
    ufe_pkg::t_field  ra_f, rb_f, sa_f, sb_f;
    logic             err_r;

    assign limit     = (r_node_cnt < ufe_pkg::NODE_LIMIT) ? r_node_cnt : ufe_pkg::NODE_LIMIT;
    assign a_raw     = $unsigned(i_in.index_a);
    assign b_raw     = $unsigned(i_in.index_b);
    assign cmd_in    = ufe_pkg::t_cmd'(i_in.cmd);
    assign ca_in     = ufe_pkg::classify(a_raw, limit);
    assign cb_in     = ufe_pkg::classify(b_raw, limit);
    assign uses_b_in = (cmd_in == ufe_pkg::CMD_UNITE) || (cmd_in == ufe_pkg::CMD_SAME);
    assign err_in    = (ca_in == ufe_pkg::CLS_RANGE)
                       || (uses_b_in && (cb_in == ufe_pkg::CLS_RANGE));
    assign start_a   = !err_in && (ca_in == ufe_pkg::CLS_OK);
    assign start_b   = !err_in && (cmd_in == ufe_pkg::CMD_SAME)
                       && (ca_in != ufe_pkg::CLS_OK) && (cb_in == ufe_pkg::CLS_OK);

    assign in_ready  = (r_state == ufe_pkg::S_IDLE);
    assign accept    = in_ready && i_in.valid;
    assign i_in.ready = in_ready;

    assign walk_found  = (r_par_q == r_cur);
    assign comp_done   = (r_cur == r_root);
    assign need_b      = (r_cmd == ufe_pkg::CMD_UNITE)
                         || ((r_cmd == ufe_pkg::CMD_SAME) && (r_cb == ufe_pkg::CLS_OK));
    assign link_needed = (r_cmd == ufe_pkg::CMD_UNITE) && (r_ra != r_root);
    assign out_free    = !r_ov || o_out.ready;
    assign sz_sum      = r_sza + r_sz_q;

    assign ra_f  = ufe_pkg::FIELD_W'(r_ra);
    assign rb_f  = ufe_pkg::FIELD_W'(r_rb);
    assign sa_f  = (r_ca == ufe_pkg::CLS_OK) ? ra_f : ufe_pkg::UNASG;
    assign sb_f  = (r_cb == ufe_pkg::CLS_OK) ? rb_f : ufe_pkg::UNASG;
    assign err_r = (r_ca == ufe_pkg::CLS_RANGE)
                   || (((r_cmd == ufe_pkg::CMD_UNITE) || (r_cmd == ufe_pkg::CMD_SAME))
                       && (r_cb == ufe_pkg::CLS_RANGE));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ufe_pkg::S_CLEAR: begin
                if (r_clr == ufe_pkg::t_idx'(ufe_pkg::NODES - 1)) n_state = ufe_pkg::S_IDLE;
            end
            ufe_pkg::S_IDLE: begin
                if (accept) begin
                    if (start_a || start_b) n_state = ufe_pkg::S_WALK;
                    else                    n_state = ufe_pkg::S_RESP;
                end
            end
            ufe_pkg::S_WALK: begin
                if (walk_found) begin
                    n_state = r_walk_only ? ufe_pkg::S_RESP : ufe_pkg::S_COMP;
                end
            end
            ufe_pkg::S_COMP: begin
                if (comp_done) n_state = ufe_pkg::S_NEXT;
            end
            ufe_pkg::S_NEXT: begin
                if (!r_on_b) begin
                    if (need_b)                          n_state = ufe_pkg::S_WALK;
                    else if (r_cmd == ufe_pkg::CMD_SIZE) n_state = ufe_pkg::S_SZ;
                    else                                 n_state = ufe_pkg::S_RESP;
                end else begin
                    n_state = link_needed ? ufe_pkg::S_USZA : ufe_pkg::S_RESP;
                end
            end
            ufe_pkg::S_SZ:   n_state = ufe_pkg::S_RESP;
            ufe_pkg::S_USZA: n_state = ufe_pkg::S_USZB;
            ufe_pkg::S_USZB: n_state = ufe_pkg::S_RESP;
            ufe_pkg::S_RESP: begin
                if (out_free) n_state = ufe_pkg::S_IDLE;
            end
            default: n_state = ufe_pkg::S_CLEAR;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_ca        = r_ca;
        n_cb        = r_cb;
        n_b         = r_b;
        n_cur       = r_cur;
        n_start     = r_start;
        n_root      = r_root;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_on_b      = r_on_b;
        n_walk_only = r_walk_only;
        n_gsz       = r_gsz;
        n_sza       = r_sza;
        n_o_root    = r_o_root;
        n_o_same    = r_o_same;
        n_o_gsz     = r_o_gsz;
        n_o_status  = r_o_status;
        n_ov        = r_ov && !o_out.ready;
        par_we      = 1'b0;
        par_wa      = r_cur;
        par_wd      = r_root;
        par_ra      = r_cur;
        sz_we       = 1'b0;
        sz_wa       = r_ra;
        sz_wd       = sz_sum;
        sz_ra       = r_root;
        unique case (r_state)
            // Load each entry as its own root with size one
            ufe_pkg::S_CLEAR: begin
                par_we = 1'b1;
                par_wa = r_clr;
                par_wd = r_clr;
                sz_we  = 1'b1;
                sz_wa  = r_clr;
                sz_wd  = ufe_pkg::t_size'(1);
                n_clr  = r_clr + ufe_pkg::t_idx'(1);
            end
            // Latch the command and start the first find
            ufe_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd       = cmd_in;
                    n_ca        = ca_in;
                    n_cb        = cb_in;
                    n_b         = b_raw[ufe_pkg::IDX_W-1:0];
                    n_on_b      = start_b;
                    n_walk_only = (cmd_in == ufe_pkg::CMD_UNITE) && (cb_in == ufe_pkg::CLS_UNASG);
                    if (start_b) begin
                        n_cur   = b_raw[ufe_pkg::IDX_W-1:0];
                        n_start = b_raw[ufe_pkg::IDX_W-1:0];
                        par_ra  = b_raw[ufe_pkg::IDX_W-1:0];
                    end else begin
                        n_cur   = a_raw[ufe_pkg::IDX_W-1:0];
                        n_start = a_raw[ufe_pkg::IDX_W-1:0];
                        par_ra  = a_raw[ufe_pkg::IDX_W-1:0];
                    end
                end
            end
            // Follow parent links up to the root
            ufe_pkg::S_WALK: begin
                if (walk_found) begin
                    n_root = r_cur;
                    if (r_walk_only) begin
                        n_ra = r_cur;
                    end else begin
                        n_cur  = r_start;
                        par_ra = r_start;
                    end
                end else begin
                    n_cur  = r_par_q;
                    par_ra = r_par_q;
                end
            end
            // Rewrite each link on the path to point at the root
            ufe_pkg::S_COMP: begin
                if (!comp_done) begin
                    par_we = 1'b1;
                    par_wa = r_cur;
                    par_wd = r_root;
                    n_cur  = r_par_q;
                    par_ra = r_par_q;
                end
            end
            // Record the root and pick the next step
            ufe_pkg::S_NEXT: begin
                if (!r_on_b) begin
                    n_ra = r_root;
                    if (need_b) begin
                        n_cur   = r_b;
                        n_start = r_b;
                        par_ra  = r_b;
                        n_on_b  = 1'b1;
                    end else begin
                        sz_ra = r_root;
                    end
                end else begin
                    n_rb  = r_root;
                    sz_ra = r_ra;
                end
            end
            ufe_pkg::S_SZ: begin
                n_gsz = r_sz_q;
            end
            ufe_pkg::S_USZA: begin
                n_sza = r_sz_q;
                sz_ra = r_rb;
            end
            // Link the smaller group under the larger one
            ufe_pkg::S_USZB: begin
                par_we = 1'b1;
                sz_we  = 1'b1;
                sz_wd  = sz_sum;
                if (r_sza < r_sz_q) begin
                    par_wa = r_ra;
                    par_wd = r_rb;
                    sz_wa  = r_rb;
                    n_ra   = r_rb;
                end else begin
                    par_wa = r_rb;
                    par_wd = r_ra;
                    sz_wa  = r_ra;
                end
            end
            // Form the result once the output slot is free
            ufe_pkg::S_RESP: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_root   = ufe_pkg::UNASG;
                    n_o_same   = 1'b0;
                    n_o_gsz    = '0;
                    n_o_status = ufe_pkg::ST_OK;
                    if (err_r) begin
                        n_o_status = ufe_pkg::ST_RANGE;
                    end else begin
                        case (r_cmd)
                            ufe_pkg::CMD_FIND: begin
                                if (r_ca == ufe_pkg::CLS_UNASG) n_o_status = ufe_pkg::ST_UNASG;
                                else                            n_o_root   = ra_f;
                            end
                            ufe_pkg::CMD_UNITE: begin
                                if ((r_ca == ufe_pkg::CLS_UNASG)
                                    || (r_cb == ufe_pkg::CLS_UNASG)) begin
                                    n_o_status = ufe_pkg::ST_UNASG;
                                end
                                if (r_ca == ufe_pkg::CLS_OK) n_o_root = ra_f;
                            end
                            ufe_pkg::CMD_SAME: begin
                                n_o_root = sa_f;
                                n_o_same = (sa_f == sb_f);
                                if ((r_ca == ufe_pkg::CLS_UNASG)
                                    || (r_cb == ufe_pkg::CLS_UNASG)) begin
                                    n_o_status = ufe_pkg::ST_UNASG;
                                end
                            end
                            default: begin
                                if (r_ca == ufe_pkg::CLS_UNASG) begin
                                    n_o_status = ufe_pkg::ST_UNASG;
                                end else begin
                                    n_o_root = ra_f;
                                    n_o_gsz  = ufe_pkg::FIELD_W'(r_gsz);
                                end
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ufe_pkg::S_CLEAR;
            r_clr      <= '0;
            r_node_cnt <= ufe_pkg::CFG_RESET;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            if (i_cfg_we) r_node_cnt <= i_cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_ca        <= n_ca;
        r_cb        <= n_cb;
        r_b         <= n_b;
        r_cur       <= n_cur;
        r_start     <= n_start;
        r_root      <= n_root;
        r_ra        <= n_ra;
        r_rb        <= n_rb;
        r_on_b      <= n_on_b;
        r_walk_only <= n_walk_only;
        r_gsz       <= n_gsz;
        r_sza       <= n_sza;
        r_o_root    <= n_o_root;
        r_o_same    <= n_o_same;
        r_o_gsz     <= n_o_gsz;
        r_o_status  <= n_o_status;
    end

    // Parent memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (par_we) r_par_mem[par_wa] <= par_wd;
        r_par_q <= r_par_mem[par_ra];
    end

    // Size memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (sz_we) r_sz_mem[sz_wa] <= sz_wd;
        r_sz_q <= r_sz_mem[sz_ra];
    end

    assign o_out.valid      = r_ov;
    assign o_out.root       = $signed(r_o_root);
    assign o_out.is_same    = r_o_same;
    assign o_out.group_size = r_o_gsz;
    assign o_out.status     = r_o_status;

endmodule

`default_nettype wire

>>> hdl/ufe_checker.sv
`default_nettype none

module ufe_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [ufe_pkg::FIELD_W-1:0]  i_out_root,
    input wire logic                         i_out_is_same,
    input wire logic [ufe_pkg::FIELD_W-1:0]  i_out_group_size,
    input wire logic [ufe_pkg::STAT_W-1:0]   i_out_status
);

    // Reset starts the clearing pass, so no command is taken right after it
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // One command at a time: busy once a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready in the cycle after a transaction");

    // A range error answers with an unassigned root and the other fields cleared
    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == ufe_pkg::ST_RANGE)
        |-> (i_out_root == ufe_pkg::UNASG) && !i_out_is_same && (i_out_group_size == '0))
        else $error("range error with nonzero result fields");

    // Unassigned root never carries a group size, and is_same excludes a size
    a_size_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_root != ufe_pkg::UNASG) || (i_out_group_size == '0))
                        && !(i_out_is_same && (i_out_group_size != '0)))
        else $error("group size reported with unassigned root or with is_same");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_out_root) && $stable(i_out_status)
            && $stable(i_out_group_size) && $stable(i_out_is_same))
        else $error("stalled result changed");

endmodule

bind union_find_engine_unit ufe_checker u_ufe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_root       (o_out.root),
    .i_out_is_same    (o_out.is_same),
    .i_out_group_size (o_out.group_size),
    .i_out_status     (o_out.status)
);

`default_nettype wire

>>> dv/union_find_engine_unit_test.sv
`default_nettype none

module union_find_engine_unit_test;
    import ufe_pkg::*;

    localparam int IDLE_PCT   = 31;
    localparam int STALL_CAP  = 4000;
    localparam int SETTLE_CYC = 4;
    localparam int TAIL_CYC   = 64;

    typedef struct packed {
        t_cmd   cmd;
        t_field a;
        t_field b;
    } t_request;

    typedef struct packed {
        t_field  root;
        logic    is_same;
        t_field  group_size;
        t_status status;
    } t_answer;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_field i_cfg_wdata;

    ufe_in_if  in_if ();
    ufe_out_if out_if ();

    union_find_engine_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Shadow copy of the forest and the element-count register
    t_idx   link_mem [NODES];
    t_field count_mem [NODES];
    t_field node_cfg = CFG_RESET;

    t_request cmd_backlog [$];
    t_answer  due_answers [$];
    t_request offer;
    t_request taken;
    t_answer  seen;
    t_answer  want;
    bit       in_moved = 1'b0;
    bit       jitter = 1'b1;
    int       issued = 0;
    int       answered = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sort an index into valid, unassigned or out of range for the current count
    function automatic t_cls grade(input t_field v);
        int lim;
        lim = (node_cfg > NODES) ? NODES : int'(node_cfg);
        if (v == UNASG) return CLS_UNASG;
        if (v[FIELD_W-1] || v >= lim) return CLS_RANGE;
        return CLS_OK;
    endfunction

    // Follow parent links up to the root without touching them
    function automatic t_idx top_of(input t_idx x);
        int n;
        n = 0;
        while (link_mem[x] != x && n < NODES) begin
            x = link_mem[x];
            n++;
        end
        return x;
    endfunction

    // Find the root, then point every node on the path straight at it
    function automatic t_idx flatten(input t_idx x);
        t_idx r;
        t_idx nx;
        int   n;
        r = top_of(x);
        n = 0;
        while (x != r && n < NODES) begin
            nx = link_mem[x];
            link_mem[x] = r;
            x = nx;
            n++;
        end
        return r;
    endfunction

    // Apply one command to the shadow forest and work out its answer
    function automatic t_answer resolve_command(input t_request q);
        t_answer ans;
        t_cls    ca;
        t_cls    cb;
        bit      uses_b;
        t_idx    ra;
        t_idx    rb;
        t_field  fa;
        t_field  fb;
        ans.root       = UNASG;
        ans.is_same    = 1'b0;
        ans.group_size = '0;
        ans.status     = ST_OK;
        ca = grade(q.a);
        cb = grade(q.b);
        uses_b = (q.cmd == CMD_UNITE) || (q.cmd == CMD_SAME);
        if (ca == CLS_RANGE || (uses_b && cb == CLS_RANGE)) begin
            ans.status = ST_RANGE;
        end else begin
            case (q.cmd)
                CMD_FIND: begin
                    if (ca == CLS_UNASG) begin
                        ans.status = ST_UNASG;
                    end else begin
                        ans.root = {1'b0, flatten(q.a[IDX_W-1:0])};
                    end
                end
                CMD_UNITE: begin
                    if (ca == CLS_UNASG || cb == CLS_UNASG) begin
                        ans.status = ST_UNASG;
                        if (ca == CLS_OK) ans.root = {1'b0, top_of(q.a[IDX_W-1:0])};
                    end else begin
                        ra = flatten(q.a[IDX_W-1:0]);
                        rb = flatten(q.b[IDX_W-1:0]);
                        // Hang the smaller group under the larger; ties go under a
                        if (ra != rb) begin
                            if (count_mem[ra] < count_mem[rb]) begin
                                link_mem[ra] = rb;
                                count_mem[rb] = count_mem[rb] + count_mem[ra];
                                ra = rb;
                            end else begin
                                link_mem[rb] = ra;
                                count_mem[ra] = count_mem[ra] + count_mem[rb];
                            end
                        end
                        ans.root = {1'b0, ra};
                    end
                end
                CMD_SAME: begin
                    fa = UNASG;
                    fb = UNASG;
                    if (ca == CLS_OK) fa = {1'b0, flatten(q.a[IDX_W-1:0])};
                    if (cb == CLS_OK) fb = {1'b0, flatten(q.b[IDX_W-1:0])};
                    if (ca == CLS_UNASG || cb == CLS_UNASG) ans.status = ST_UNASG;
                    ans.root    = fa;
                    ans.is_same = (fa == fb);
                end
                default: begin
                    if (ca == CLS_UNASG) begin
                        ans.status = ST_UNASG;
                    end else begin
                        ra = flatten(q.a[IDX_W-1:0]);
                        ans.root       = {1'b0, ra};
                        ans.group_size = count_mem[ra];
                    end
                end
            endcase
        end
        return ans;
    endfunction

    // Mostly indices from a small window so groups grow; some edges and noise
    function automatic t_field pick_index();
        int lim;
        int r;
        int span;
        lim = (node_cfg > NODES) ? NODES : int'(node_cfg);
        r = $urandom_range(99);
        if (r < 6) return UNASG;
        if (r < 11 || lim == 0) return t_field'($urandom);
        if (r < 15) return t_field'(lim);
        if (r < 30) return t_field'($urandom_range(lim - 1));
        span = (lim < 48) ? lim : 48;
        return t_field'($urandom_range(span - 1));
    endfunction

    task automatic queue_cmd(input t_cmd c, input int a, input int b);
        t_request q;
        q.cmd = c;
        q.a   = t_field'(a);
        q.b   = t_field'(b);
        cmd_backlog.push_back(q);
        issued++;
    endtask

    task automatic queue_random(input int count);
        int r;
        t_cmd c;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 40) c = CMD_UNITE;
            else if (r < 60) c = CMD_FIND;
            else if (r < 80) c = CMD_SAME;
            else c = CMD_SIZE;
            queue_cmd(c, int'(pick_index()), int'(pick_index()));
        end
    endtask

    // Hold off until every issued command has been answered
    task automatic drain();
        while (answered < issued) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_count(input int v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_field'(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic flag(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    // Hold the current transaction until it is taken, then offer the next one
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(in_if.valid && !in_moved)) begin
                if (cmd_backlog.size() != 0 && (!jitter || $urandom_range(99) >= IDLE_PCT)) begin
                    offer = cmd_backlog.pop_front();
                    in_if.valid   <= 1'b1;
                    in_if.cmd     <= offer.cmd;
                    in_if.index_a <= offer.a;
                    in_if.index_b <= offer.b;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= !jitter || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Check each result transaction, then predict for each accepted command
    always @(posedge i_clk) begin
        in_moved = in_if.valid && in_if.ready;
        if (i_cfg_we) node_cfg = i_cfg_wdata;
        if (out_if.valid && out_if.ready) begin
            seen.root       = out_if.root;
            seen.is_same    = out_if.is_same;
            seen.group_size = out_if.group_size;
            seen.status     = t_status'(out_if.status);
            if (due_answers.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual root %0d status %0d",
                         $time, $signed(seen.root), seen.status);
                mismatches++;
            end else begin
                want = due_answers.pop_front();
                answered++;
                flag("root", $signed(want.root), $signed(seen.root));
                flag("is_same", want.is_same, seen.is_same);
                flag("group_size", want.group_size, seen.group_size);
                flag("status", want.status, seen.status);
            end
        end
        if (in_moved) begin
            taken.cmd = t_cmd'(in_if.cmd);
            taken.a   = in_if.index_a;
            taken.b   = in_if.index_b;
            due_answers.push_back(resolve_command(taken));
        end
        // Advance the watchdog on cycles that move nothing
        if (in_moved || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_CAP) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_CAP);
            $display("union_find_engine_unit verification failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < NODES; k++) begin
            link_mem[k]  = t_idx'(k);
            count_mem[k] = t_field'(1);
        end
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_if.valid   = 1'b0;
        in_if.cmd     = '0;
        in_if.index_a = '0;
        in_if.index_b = '0;
        out_if.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_count(1024);

        // Directed: edge indices, tie and size-ordered links, unassigned and range cases
        queue_cmd(CMD_FIND, 0, 0);
        queue_cmd(CMD_FIND, 1023, 1023);
        queue_cmd(CMD_UNITE, 0, 1);
        queue_cmd(CMD_UNITE, 2, 3);
        queue_cmd(CMD_UNITE, 3, 0);
        queue_cmd(CMD_UNITE, 1023, 1);
        queue_cmd(CMD_SIZE, 1023, 0);
        queue_cmd(CMD_SAME, 0, 3);
        queue_cmd(CMD_SAME, 0, 500);
        queue_cmd(CMD_FIND, 1, 0);
        queue_cmd(CMD_UNITE, -1, 5);
        queue_cmd(CMD_UNITE, 1, -1);
        queue_cmd(CMD_SAME, -1, -1);
        queue_cmd(CMD_SAME, -1, 3);
        queue_cmd(CMD_SAME, 3, -1);
        queue_cmd(CMD_FIND, -1, 7);
        queue_cmd(CMD_SIZE, -1, 7);
        queue_cmd(CMD_FIND, -2, 0);
        queue_cmd(CMD_SIZE, -1024, 0);
        queue_cmd(CMD_UNITE, 0, -2);
        queue_cmd(CMD_SAME, -3, 0);
        queue_cmd(CMD_FIND, 5, -5);
        queue_cmd(CMD_UNITE, 4, 4);
        queue_cmd(CMD_SIZE, 2, -1);
        queue_cmd(CMD_UNITE, 600, 2);
        drain();

        set_count(16);
        queue_random(200);
        drain();

        // Count above the store depth, with no idling on either side
        set_count(2047);
        jitter = 1'b0;
        queue_random(150);
        drain();
        jitter = 1'b1;

        set_count(1);
        queue_random(40);
        drain();

        set_count(0);
        queue_random(30);
        drain();

        set_count($urandom_range(1024, 2));
        queue_random(130);
        drain();

        set_count(1024);
        queue_random(200);
        drain();

        repeat (TAIL_CYC) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("union_find_engine_unit verification clean");
        end else begin
            $display("union_find_engine_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
